// ===== hw/rtl/mqtt_packet_receive_parser_top_macros.svh =====
// Assertion macros shared by the MQTT receive parser RTL
`ifndef MQTT_PACKET_RECEIVE_PARSER_TOP_MACROS_SVH
`define MQTT_PACKET_RECEIVE_PARSER_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define MQTTP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define MQTTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mqttp_pkg.sv =====
// Types, codes and helpers for the MQTT receive parser
package mqttp_pkg;

  localparam int MAX_LENGTH_BYTES_DEF = 4;

  typedef logic [3:0]  role_t;
  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  ptype_t;
  typedef logic [1:0]  qos_t;
  typedef logic [15:0] pid_t;
  typedef logic [2:0]  event_t;
  typedef logic [27:0] len_t;

  // byte roles
  localparam role_t ROLE_HDR     = 4'd0;
  localparam role_t ROLE_REJECT  = 4'd1;
  localparam role_t ROLE_LEN     = 4'd2;
  localparam role_t ROLE_TOPLEN  = 4'd3;
  localparam role_t ROLE_TOPIC   = 4'd4;
  localparam role_t ROLE_PID     = 4'd5;
  localparam role_t ROLE_PROP    = 4'd6;
  localparam role_t ROLE_PAYLOAD = 4'd7;
  localparam role_t ROLE_OTHER   = 4'd8;

  // packet events
  localparam event_t EV_NONE       = 3'd0;
  localparam event_t EV_CONNACK    = 3'd1;
  localparam event_t EV_PUBLISH    = 3'd2;
  localparam event_t EV_PINGRESP   = 3'd3;
  localparam event_t EV_DISCONNECT = 3'd4;
  localparam event_t EV_ACK        = 3'd5;
  localparam event_t EV_UNHANDLED  = 3'd6;

  // control packet types
  localparam ptype_t T_RESERVED   = 4'd0;
  localparam ptype_t T_CONNACK    = 4'd2;
  localparam ptype_t T_PUBLISH    = 4'd3;
  localparam ptype_t T_PUBACK     = 4'd4;
  localparam ptype_t T_PUBREC     = 4'd5;
  localparam ptype_t T_PUBREL     = 4'd6;
  localparam ptype_t T_PUBCOMP    = 4'd7;
  localparam ptype_t T_SUBACK     = 4'd9;
  localparam ptype_t T_PINGREQ    = 4'd12;
  localparam ptype_t T_PINGRESP   = 4'd13;
  localparam ptype_t T_DISCONNECT = 4'd14;

  typedef struct packed {
    role_t  byte_role;
    byte_t  data_byte;
    ptype_t packet_type;
    qos_t   qos_level;
    logic   retain_flag;
    pid_t   packet_id;
    logic   packet_end;
    event_t packet_event;
    logic   format_error;
    len_t   bytes_left;
    logic   property_present;
    logic   connected;
  } res_t;

  function automatic event_t event_of(input ptype_t t);
    event_t ev;
    unique case (t) inside
      T_CONNACK:    ev = EV_CONNACK;
      T_PUBLISH:    ev = EV_PUBLISH;
      T_PINGRESP:   ev = EV_PINGRESP;
      T_DISCONNECT: ev = EV_DISCONNECT;
      T_PUBACK, T_PUBREC, T_PUBREL, T_PUBCOMP, T_SUBACK, T_PINGREQ: ev = EV_ACK;
      default:      ev = EV_UNHANDLED;
    endcase
    return ev;
  endfunction

endpackage

// ===== hw/rtl/mqttp_if.sv =====
// Valid/ready channel interfaces for received bytes and labeled results
interface mqttp_in_if;
  import mqttp_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mqttp_out_if;
  import mqttp_pkg::*;
  logic   valid;
  logic   ready;
  role_t  byte_role;
  byte_t  data_byte;
  ptype_t packet_type;
  qos_t   qos_level;
  logic   retain_flag;
  pid_t   packet_id;
  logic   packet_end;
  event_t packet_event;
  logic   format_error;
  len_t   bytes_left;
  logic   property_present;
  logic   connected;
  modport source (output valid, output byte_role, output data_byte, output packet_type,
                  output qos_level, output retain_flag, output packet_id,
                  output packet_end, output packet_event, output format_error,
                  output bytes_left, output property_present, output connected,
                  input ready);
  modport sink   (input valid, input byte_role, input data_byte, input packet_type,
                  input qos_level, input retain_flag, input packet_id,
                  input packet_end, input packet_event, input format_error,
                  input bytes_left, input property_present, input connected,
                  output ready);
endinterface

// ===== hw/rtl/mqttp_core.sv =====
// Parser state and per-byte step logic of the MQTT receive parser
module mqttp_core #(
  parameter int MAX_LENGTH_BYTES = mqttp_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  mqttp_pkg::byte_t rx_byte,
  output mqttp_pkg::res_t  res
);
  import mqttp_pkg::*;

  localparam logic [3:0] PH_HDR   = 4'd0;
  localparam logic [3:0] PH_LEN   = 4'd1;
  localparam logic [3:0] PH_TLH   = 4'd2;
  localparam logic [3:0] PH_TLL   = 4'd3;
  localparam logic [3:0] PH_TOP   = 4'd4;
  localparam logic [3:0] PH_PIDH  = 4'd5;
  localparam logic [3:0] PH_PIDL  = 4'd6;
  localparam logic [3:0] PH_PROP0 = 4'd7;
  localparam logic [3:0] PH_PROPV = 4'd8;
  localparam logic [3:0] PH_PAY   = 4'd9;
  localparam logic [3:0] PH_OTHER = 4'd10;

  localparam logic [2:0] MAX_LB = 3'(MAX_LENGTH_BYTES);

  logic [3:0]  phase_r, phase_nxt;
  ptype_t      type_r, type_nxt;
  qos_t        qos_r, qos_nxt;
  logic        retain_r, retain_nxt;
  len_t        rem_r, rem_nxt;
  logic [1:0]  vidx_r, vidx_nxt;
  logic [15:0] topic_r, topic_nxt;
  pid_t        pid_r, pid_nxt;
  logic        prop_r, prop_nxt;
  logic        conn_r, conn_nxt;

  logic        overrun;
  len_t        len_or;
  len_t        rem_dec;
  logic [15:0] topic_or;
  logic [15:0] topic_dec;
  logic [3:0]  after_topic;
  role_t       role;
  logic        pkt_end;
  logic        err;
  event_t      ev;
  len_t        left;

  assign overrun   = ({1'b0, vidx_r} + 3'd1) >= MAX_LB;
  assign rem_dec   = (rem_r != '0) ? rem_r - 28'd1 : rem_r;
  assign topic_or  = topic_r | {8'd0, rx_byte};
  assign topic_dec = topic_r - 16'd1;
  assign after_topic = (qos_r != '0) ? PH_PIDH : PH_PROP0;

  always_comb begin
    case (vidx_r)
      2'd0:    len_or = rem_r | {21'd0, rx_byte[6:0]};
      2'd1:    len_or = rem_r | {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_or = rem_r | {7'd0, rx_byte[6:0], 14'd0};
      default: len_or = rem_r | {rx_byte[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    qos_nxt    = qos_r;
    retain_nxt = retain_r;
    rem_nxt    = rem_r;
    vidx_nxt   = vidx_r;
    topic_nxt  = topic_r;
    pid_nxt    = pid_r;
    prop_nxt   = prop_r;
    conn_nxt   = conn_r;
    role       = ROLE_OTHER;
    pkt_end    = 1'b0;
    err        = 1'b0;
    ev         = EV_NONE;
    left       = '0;

    unique case (phase_r) inside
      PH_LEN: begin
        role    = ROLE_LEN;
        rem_nxt = len_or;
        if (rx_byte[7]) begin
          if (overrun) begin
            err     = 1'b1;
            pkt_end = 1'b1;
          end else begin
            vidx_nxt = vidx_r + 2'd1;
          end
        end else begin
          left = len_or;
          if (len_or == '0) begin
            pkt_end = 1'b1;
            err     = (type_r == T_PUBLISH);
          end else begin
            phase_nxt = (type_r == T_PUBLISH) ? PH_TLH : PH_OTHER;
          end
        end
      end
      PH_TLH, PH_TLL, PH_TOP, PH_PIDH, PH_PIDL, PH_PROP0, PH_PROPV, PH_PAY,
      PH_OTHER: begin
        rem_nxt = rem_dec;
        case (phase_r)
          PH_TLH: begin
            role      = ROLE_TOPLEN;
            topic_nxt = {rx_byte, 8'd0};
            phase_nxt = PH_TLL;
          end
          PH_TLL: begin
            role      = ROLE_TOPLEN;
            topic_nxt = topic_or;
            phase_nxt = (topic_or != '0) ? PH_TOP : after_topic;
          end
          PH_TOP: begin
            role      = ROLE_TOPIC;
            topic_nxt = topic_dec;
            if (topic_dec == '0) phase_nxt = after_topic;
          end
          PH_PIDH: begin
            role      = ROLE_PID;
            pid_nxt   = {rx_byte, 8'd0};
            phase_nxt = PH_PIDL;
          end
          PH_PIDL: begin
            role      = ROLE_PID;
            pid_nxt   = pid_r | {8'd0, rx_byte};
            phase_nxt = PH_PROP0;
          end
          PH_PROP0: begin
            role = ROLE_PROP;
            if (rx_byte == '0) begin
              phase_nxt = PH_PAY;
            end else begin
              prop_nxt = 1'b1;
              vidx_nxt = 2'd0;
              if (rx_byte[7]) begin
                // first byte of the varint, index 0
                if (MAX_LB <= 3'd1) begin
                  err     = 1'b1;
                  pkt_end = 1'b1;
                end else begin
                  vidx_nxt  = 2'd1;
                  phase_nxt = PH_PROPV;
                end
              end else begin
                phase_nxt = PH_PAY;
              end
            end
          end
          PH_PROPV: begin
            role = ROLE_PROP;
            if (rx_byte[7]) begin
              if (overrun) begin
                err     = 1'b1;
                pkt_end = 1'b1;
              end else begin
                vidx_nxt = vidx_r + 2'd1;
              end
            end else begin
              phase_nxt = PH_PAY;
            end
          end
          PH_PAY:  role = ROLE_PAYLOAD;
          default: role = ROLE_OTHER;
        endcase
        left = rem_dec;
        if (!err && rem_dec == '0) begin
          pkt_end = 1'b1;
          if (phase_nxt != PH_PAY && phase_nxt != PH_OTHER) err = 1'b1;
        end
      end
      default: begin
        type_nxt   = rx_byte[7:4];
        qos_nxt    = '0;
        retain_nxt = 1'b0;
        pid_nxt    = '0;
        prop_nxt   = 1'b0;
        rem_nxt    = '0;
        vidx_nxt   = '0;
        topic_nxt  = '0;
        if (rx_byte[7:4] == T_RESERVED) begin
          role      = ROLE_REJECT;
          phase_nxt = PH_HDR;
        end else begin
          role = ROLE_HDR;
          if (rx_byte[7:4] == T_PUBLISH) begin
            qos_nxt    = rx_byte[2:1];
            retain_nxt = rx_byte[0];
          end
          phase_nxt = PH_LEN;
        end
      end
    endcase

    if (pkt_end) begin
      phase_nxt = PH_HDR;
      if (!err) begin
        ev = event_of(type_nxt);
        if (type_nxt == T_CONNACK)        conn_nxt = 1'b1;
        else if (ev == EV_DISCONNECT)     conn_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    res.byte_role        = role;
    res.data_byte        = rx_byte;
    res.packet_type      = type_nxt;
    res.qos_level        = qos_nxt;
    res.retain_flag      = retain_nxt;
    res.packet_id        = pid_nxt;
    res.packet_end       = pkt_end;
    res.packet_event     = ev;
    res.format_error     = err;
    res.bytes_left       = left;
    res.property_present = prop_nxt;
    res.connected        = conn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR;
      type_r   <= '0;
      qos_r    <= '0;
      retain_r <= 1'b0;
      rem_r    <= '0;
      vidx_r   <= '0;
      topic_r  <= '0;
      pid_r    <= '0;
      prop_r   <= 1'b0;
      conn_r   <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      qos_r    <= qos_nxt;
      retain_r <= retain_nxt;
      rem_r    <= rem_nxt;
      vidx_r   <= vidx_nxt;
      topic_r  <= topic_nxt;
      pid_r    <= pid_nxt;
      prop_r   <= prop_nxt;
      conn_r   <= conn_nxt;
    end
  end

endmodule

// ===== hw/rtl/mqtt_packet_receive_parser_top.sv =====
// Top level of the MQTT receive parser: input register, parser core, result register
//
// Usage:
//   in_ch carries one received byte per transfer (valid/ready, rx_byte).
//   out_ch returns one labeled result per byte, in order: role, echoed byte,
//   packet type, qos, retain, packet id, end/event/error, bytes left,
//   property flag and the connected flag after that byte.
// Path: a byte taken on in_ch is presented on out_ch after two register stages,
//   first the input register, then the result register.
// Throughput: one byte per cycle while out_ch keeps up; the parser state updates
//   in one combinational step as a byte moves from input to result register.
// Stall: when out_ch is held off, the result register keeps its transfer and
//   the input register can still take one more byte; in_ch.ready then drops
//   until the result is taken.
// Reset (rst_n low, synchronous): both stages empty, parser waits for a
//   fixed header, connected flag cleared.
`include "mqtt_packet_receive_parser_top_macros.svh"

module mqtt_packet_receive_parser_top #(
  parameter int MAX_LENGTH_BYTES = mqttp_pkg::MAX_LENGTH_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mqttp_in_if.sink   in_ch,
  mqttp_out_if.source out_ch
);
  import mqttp_pkg::*;

  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r;
  logic  out_valid_r, out_valid_nxt;
  res_t  res_r;
  res_t  res;
  logic  s2_free;
  logic  step_en;
  logic  in_xfer;
  logic  ev_bad;
  logic  err_bad;
  logic  hdr_bad;

  assign s2_free  = !out_valid_r || out_ch.ready;
  assign step_en  = s1_valid_r && s2_free;
  assign in_ch.ready = !s1_valid_r || s2_free;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (step_en ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = step_en ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  mqttp_core #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_byte_r <= in_ch.rx_byte;
    if (step_en) res_r <= res;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.byte_role        = res_r.byte_role;
  assign out_ch.data_byte        = res_r.data_byte;
  assign out_ch.packet_type      = res_r.packet_type;
  assign out_ch.qos_level        = res_r.qos_level;
  assign out_ch.retain_flag      = res_r.retain_flag;
  assign out_ch.packet_id        = res_r.packet_id;
  assign out_ch.packet_end       = res_r.packet_end;
  assign out_ch.packet_event     = res_r.packet_event;
  assign out_ch.format_error     = res_r.format_error;
  assign out_ch.bytes_left       = res_r.bytes_left;
  assign out_ch.property_present = res_r.property_present;
  assign out_ch.connected        = res_r.connected;

  assign ev_bad  = out_valid_r && res_r.packet_event != EV_NONE &&
                   !(res_r.packet_end && !res_r.format_error);
  assign err_bad = out_valid_r && res_r.format_error && !res_r.packet_end;
  assign hdr_bad = out_valid_r &&
                   (res_r.byte_role == ROLE_HDR || res_r.byte_role == ROLE_REJECT) &&
                   (res_r.bytes_left != '0 || res_r.packet_end);

  `MQTTP_ASSERT(a_event_only_at_clean_end, !ev_bad, "event outside a clean packet end")
  `MQTTP_ASSERT(a_error_ends_packet, !err_bad, "format error without packet end")
  `MQTTP_ASSERT(a_header_no_body, !hdr_bad, "header byte with body count or end")
  `MQTTP_ASSERT_NXT(a_step_loads_result, step_en, out_valid_r, "stepped byte not presented")

endmodule

// ===== verif/mqttp_checker.sv =====
// Scoreboard for the MQTT receive parser: labels every accepted byte and checks each result
`timescale 1ns / 100ps

module mqttp_checker (
  input  logic  clk,
  input  logic  rst_n,
  mqttp_in_if   in_ch,
  mqttp_out_if  out_ch,
  output int    fail_count,
  output int    pending,
  output int    checked
);
  import mqttp_pkg::*;

  localparam int VARINT_MAX_BYTES = MAX_LENGTH_BYTES_DEF;

  typedef enum logic [3:0] {
    ST_HDR, ST_LEN, ST_TOPLEN_HI, ST_TOPLEN_LO, ST_TOPIC, ST_PID_HI, ST_PID_LO,
    ST_PROP_FIRST, ST_PROP_MORE, ST_PAYLOAD, ST_BODY
  } parse_st_e;

  parse_st_e   st;
  ptype_t      cur_type;
  qos_t        cur_qos;
  logic        cur_retain;
  len_t        body_left;
  logic [1:0]  vint_idx;
  logic [15:0] topic_cnt;
  pid_t        pid_acc;
  logic        prop_seen;
  logic        link_up;

  res_t        label_q[$];

  function automatic logic vint_full();
    return int'(vint_idx) + 1 >= VARINT_MAX_BYTES;
  endfunction

  function automatic event_t end_event(input ptype_t t);
    case (t) inside
      T_CONNACK:    return EV_CONNACK;
      T_PUBLISH:    return EV_PUBLISH;
      T_PINGRESP:   return EV_PINGRESP;
      T_DISCONNECT: return EV_DISCONNECT;
      T_PUBACK, T_PUBREC, T_PUBREL, T_PUBCOMP, T_SUBACK, T_PINGREQ: return EV_ACK;
      default:      return EV_UNHANDLED;
    endcase
  endfunction

  // advances the parse state by one byte and returns its label
  function automatic res_t label_byte(input byte_t b);
    res_t      r;
    parse_st_e nxt;
    logic      abort;
    logic      fin;
    event_t    ev;
    len_t      left;
    r     = '0;
    nxt   = st;
    abort = 1'b0;
    fin   = 1'b0;
    ev    = EV_NONE;
    left  = '0;
    case (st)
      ST_HDR: begin
        cur_type   = b[7:4];
        cur_qos    = '0;
        cur_retain = 1'b0;
        pid_acc    = '0;
        prop_seen  = 1'b0;
        body_left  = '0;
        vint_idx   = '0;
        topic_cnt  = '0;
        if (b[7:4] == T_RESERVED) begin
          r.byte_role = ROLE_REJECT;
        end else begin
          r.byte_role = ROLE_HDR;
          if (b[7:4] == T_PUBLISH) begin
            cur_qos    = b[2:1];
            cur_retain = b[0];
          end
          nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        r.byte_role = ROLE_LEN;
        body_left = body_left | (len_t'(b[6:0]) << (7 * vint_idx));
        if (b[7]) begin
          if (vint_full()) begin
            abort = 1'b1;
            fin   = 1'b1;
          end else begin
            vint_idx = vint_idx + 2'd1;
          end
        end else begin
          left = body_left;
          if (body_left == '0) begin
            fin = 1'b1;
            if (cur_type == T_PUBLISH) abort = 1'b1;
          end else begin
            nxt = (cur_type == T_PUBLISH) ? ST_TOPLEN_HI : ST_BODY;
          end
        end
      end
      default: begin
        if (body_left != '0) body_left = body_left - 28'd1;
        case (st)
          ST_TOPLEN_HI: begin
            r.byte_role = ROLE_TOPLEN;
            topic_cnt = {b, 8'h00};
            nxt = ST_TOPLEN_LO;
          end
          ST_TOPLEN_LO: begin
            r.byte_role = ROLE_TOPLEN;
            topic_cnt = topic_cnt | 16'(b);
            if (topic_cnt != '0) nxt = ST_TOPIC;
            else nxt = (cur_qos != '0) ? ST_PID_HI : ST_PROP_FIRST;
          end
          ST_TOPIC: begin
            r.byte_role = ROLE_TOPIC;
            topic_cnt = topic_cnt - 16'd1;
            if (topic_cnt == '0) nxt = (cur_qos != '0) ? ST_PID_HI : ST_PROP_FIRST;
          end
          ST_PID_HI: begin
            r.byte_role = ROLE_PID;
            pid_acc = {b, 8'h00};
            nxt = ST_PID_LO;
          end
          ST_PID_LO: begin
            r.byte_role = ROLE_PID;
            pid_acc = pid_acc | 16'(b);
            nxt = ST_PROP_FIRST;
          end
          ST_PROP_FIRST: begin
            r.byte_role = ROLE_PROP;
            nxt = ST_PAYLOAD;
            if (b != 8'h00) begin
              prop_seen = 1'b1;
              vint_idx  = '0;
              if (b[7]) begin
                if (vint_full()) begin
                  abort = 1'b1;
                  fin   = 1'b1;
                  nxt   = st;
                end else begin
                  vint_idx = 2'd1;
                  nxt = ST_PROP_MORE;
                end
              end
            end
          end
          ST_PROP_MORE: begin
            r.byte_role = ROLE_PROP;
            if (b[7]) begin
              if (vint_full()) begin
                abort = 1'b1;
                fin   = 1'b1;
              end else begin
                vint_idx = vint_idx + 2'd1;
              end
            end else begin
              nxt = ST_PAYLOAD;
            end
          end
          ST_PAYLOAD: r.byte_role = ROLE_PAYLOAD;
          default:    r.byte_role = ROLE_OTHER;
        endcase
        left = body_left;
        if (!abort && body_left == '0) begin
          fin = 1'b1;
          if (nxt != ST_PAYLOAD && nxt != ST_BODY) abort = 1'b1;
        end
      end
    endcase
    if (fin) begin
      nxt = ST_HDR;
      if (!abort) begin
        ev = end_event(cur_type);
        if (cur_type == T_CONNACK) link_up = 1'b1;
        else if (ev == EV_DISCONNECT) link_up = 1'b0;
      end
    end
    st = nxt;

    r.data_byte        = b;
    r.packet_type      = cur_type;
    r.qos_level        = cur_qos;
    r.retain_flag      = cur_retain;
    r.packet_id        = pid_acc;
    r.packet_end       = fin;
    r.packet_event     = ev;
    r.format_error     = abort;
    r.bytes_left       = left;
    r.property_present = prop_seen;
    r.connected        = link_up;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      st         = ST_HDR;
      cur_type   = '0;
      cur_qos    = '0;
      cur_retain = 1'b0;
      body_left  = '0;
      vint_idx   = '0;
      topic_cnt  = '0;
      pid_acc    = '0;
      prop_seen  = 1'b0;
      link_up    = 1'b0;
      label_q.delete();
      fail_count = 0;
      checked    = 0;
      pending   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (label_q.size() == 0) begin
          fail_count++;
          $display("%0t: stray result, expected nothing, actual role %0d byte %0d",
                   $time, out_ch.byte_role, out_ch.data_byte);
        end else begin
          want = label_q.pop_front();
          got.byte_role        = out_ch.byte_role;
          got.data_byte        = out_ch.data_byte;
          got.packet_type      = out_ch.packet_type;
          got.qos_level        = out_ch.qos_level;
          got.retain_flag      = out_ch.retain_flag;
          got.packet_id        = out_ch.packet_id;
          got.packet_end       = out_ch.packet_end;
          got.packet_event     = out_ch.packet_event;
          got.format_error     = out_ch.format_error;
          got.bytes_left       = out_ch.bytes_left;
          got.property_present = out_ch.property_present;
          got.connected        = out_ch.connected;
          if (got !== want) begin
            fail_count++;
            $display("%0t: result %0d mismatch, expected %h, actual %h",
                     $time, checked, want, got);
          end
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) label_q = {label_q, label_byte(in_ch.rx_byte)};
      pending <= label_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the MQTT receive parser: byte stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_top;
  import mqttp_pkg::*;

  localparam int RANDOM_BYTES = 1750;
  localparam int IDLE_LIMIT   = 2000;

  typedef enum int {PUB_GOOD, PUB_SHORT, PUB_PROP_OVERRUN} pub_kind_e;
  typedef enum int {RCV_OPEN, RCV_RANDOM, RCV_PERIODIC, RCV_CHOKED} rcv_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  mqttp_in_if  in_ch();
  mqttp_out_if out_ch();

  int fail_count;
  int pending;
  int checked;

  byte_t     pkt[$];
  int        sent;
  int        burst_left;
  int        packets;
  int        publishes;
  int        broken;
  int        idle_cycles;
  int        rcv_cycle;
  rcv_mode_e rcv_mode;

  ptype_t ack_types[6]   = '{T_PUBACK, T_PUBREC, T_PUBREL, T_PUBCOMP, T_SUBACK, T_PINGREQ};
  ptype_t link_types[4]  = '{T_CONNACK, T_DISCONNECT, T_PINGRESP, T_PINGREQ};
  ptype_t other_types[5] = '{4'd1, 4'd8, 4'd10, 4'd11, 4'd15};

  mqtt_packet_receive_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mqttp_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rcv_cycle % 64 == 0) rcv_mode = rcv_mode_e'($urandom_range(0, 3));
    rcv_cycle++;
    case (rcv_mode)
      RCV_OPEN:     out_ch.ready <= 1'b1;
      RCV_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      RCV_PERIODIC: out_ch.ready <= rcv_cycle[3];
      default:      out_ch.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int groups_for(input int unsigned v);
    int n;
    n = 1;
    while (n < 4 && v >= (32'd1 << (7 * n))) n++;
    return n;
  endfunction

  function automatic void add_varint(input int unsigned v, input int nb);
    for (int i = 0; i < nb; i++) pkt = {pkt, byte_t'({i < nb - 1, 7'(v >> (7 * i))})};
  endfunction

  task automatic send_byte(input byte_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    sent++;
  endtask

  task automatic send_pkt();
    foreach (pkt[i]) send_byte(pkt[i]);
    pkt.delete();
    packets++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_framed(input byte_t hdr, input int unsigned blen, input bit pad_len);
    int nb;
    pkt = {pkt, hdr};
    if (hdr[7:4] != T_RESERVED) begin
      nb = groups_for(blen);
      if (pad_len) nb = $urandom_range(nb, 4);
      add_varint(blen, nb);
      repeat (blen) pkt = {pkt, byte_t'($urandom)};
    end
    send_pkt();
  endtask

  task automatic send_publish(input pub_kind_e kind);
    byte_t       body[$];
    int unsigned qos;
    int unsigned tlen;
    int unsigned pn;
    int unsigned fields;
    int unsigned nsend;
    int          nb;
    qos  = $urandom_range(0, 3);
    tlen = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 280) : $urandom_range(0, 6);
    body = {body, byte_t'(tlen >> 8)};
    body = {body, byte_t'(tlen)};
    repeat (tlen) body = {body, byte_t'($urandom)};
    if (qos != 0) repeat (2) body = {body, byte_t'($urandom)};
    if (kind == PUB_PROP_OVERRUN) begin
      repeat (4) body = {body, byte_t'({1'b1, 7'($urandom)})};
    end else if ($urandom_range(0, 2) == 0) begin
      body = {body, 8'h00};
    end else begin
      pn = $urandom_range(1, 3);
      add_varint($urandom_range(0, (32'd1 << (7 * pn)) - 1), pn);
      body = {body, pkt};
      pkt.delete();
    end
    fields = body.size();
    repeat ($urandom_range(0, 8)) body = {body, byte_t'($urandom)};
    nsend = (kind == PUB_GOOD) ? body.size() : fields;
    if (kind == PUB_SHORT) nsend = $urandom_range(0, fields - 1);
    pkt = {pkt, byte_t'({T_PUBLISH, 1'($urandom), 2'(qos), 1'($urandom)})};
    nb = groups_for(kind == PUB_PROP_OVERRUN ? body.size() : nsend);
    if ($urandom_range(0, 4) == 0) nb = $urandom_range(nb, 4);
    add_varint(kind == PUB_PROP_OVERRUN ? body.size() : nsend, nb);
    for (int i = 0; i < nsend; i++) pkt = {pkt, body[i]};
    publishes++;
    if (kind != PUB_GOOD) broken++;
    send_pkt();
  endtask

  initial begin
    int k;
    int stop_at;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reject, connack, empty publish, qos 3 with retain, property varint,
    // short body, property overrun, overlong length, padded length, disconnect
    pkt = '{8'h00, 8'h2F, 8'h00, 8'h30, 8'h00,
            8'h3F, 8'h06, 8'h00, 8'h01, 8'hFF, 8'hAB, 8'hCD, 8'h00,
            8'h32, 8'h07, 8'h00, 8'h00, 8'h12, 8'h34, 8'h81, 8'h01, 8'hFF,
            8'h32, 8'h03, 8'h00, 8'h00, 8'h00,
            8'h30, 8'h08, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80,
            8'hD0, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00,
            8'hC0, 8'h80, 8'h80, 8'h80, 8'h00, 8'hE0, 8'h00};
    send_pkt();
    drain();

    stop_at = sent + RANDOM_BYTES;
    while (sent < stop_at) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        send_publish(PUB_GOOD);
      end else if (k < 55) begin
        send_framed({ack_types[$urandom_range(0, 5)], 4'($urandom)}, $urandom_range(0, 4),
                    1'b0);
      end else if (k < 62) begin
        send_framed({link_types[$urandom_range(0, 3)], 4'($urandom)}, $urandom_range(0, 2),
                    1'b0);
      end else if (k < 68) begin
        send_framed({other_types[$urandom_range(0, 4)], 4'($urandom)}, $urandom_range(0, 4),
                    1'b0);
      end else if (k < 75) begin
        send_publish(PUB_SHORT);
      end else if (k < 79) begin
        send_publish(PUB_PROP_OVERRUN);
      end else if (k < 83) begin
        pkt = {pkt, byte_t'({4'($urandom_range(1, 15)), 4'($urandom)})};
        repeat (4) pkt = {pkt, byte_t'({1'b1, 7'($urandom)})};
        broken++;
        send_pkt();
      end else if (k < 88) begin
        send_framed({T_RESERVED, 4'($urandom)}, 0, 1'b0);
      end else if (k < 94) begin
        broken++;
        send_framed(byte_t'($urandom), $urandom_range(0, 4), 1'($urandom));
      end else begin
        send_framed({4'($urandom_range(1, 15)), 4'($urandom)}, $urandom_range(0, 5), 1'b1);
      end
      if (packets % 40 == 0) drain();
    end

    // largest remaining length; its body is never completed
    pkt = '{8'hF5, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    repeat (16) pkt = {pkt, byte_t'($urandom)};
    send_pkt();

    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d packets (%0d PUBLISH, %0d malformed or noise)",
             sent, packets, publishes, broken);
    $display("Checked %0d labeled results, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mqttp_pkg.sv
hw/rtl/mqttp_if.sv
hw/rtl/mqttp_core.sv
hw/rtl/mqtt_packet_receive_parser_top.sv
verif/mqttp_checker.sv
verif/tb_top.sv
